@@ hdl/ipd_pkg.sv @@
// shared types and constants of the ir pulse distance decoder
`timescale 1ns / 1ps

package ipd_pkg;

   // input transaction: one pin edge
   typedef struct packed {
      logic        level;
      logic [31:0] time_us;
   } req_type;

   // result transaction: repeat flag and decoded key
   typedef struct packed {
      logic       is_repeat;
      logic [7:0] key_code;
   } rsp_type;

   // configuration register indexes (byte address is 4 * index)
   localparam int unsigned RegCount      = 2;
   localparam int unsigned AddrWidth     = 3;
   localparam logic        RegOwnAddress = 1'b0;
   localparam logic        RegPulseUnit  = 1'b1;

   // register reset values
   localparam logic [15:0] OwnAddressReset = 16'd0;
   localparam logic [11:0] PulseUnitReset  = 12'd560;

   // frame layout
   localparam logic [5:0] FrameBits = 6'd32;
   localparam logic [7:0] CmdCheck  = 8'hff;

   // tolerance multipliers, already scaled: 20 percent compares 5*d with 4T..6T,
   // 10 percent compares 10*d with 9T..11T
   localparam logic [6:0] Lo20Unit1  = 7'd4;
   localparam logic [6:0] Hi20Unit1  = 7'd6;
   localparam logic [6:0] Lo20Unit3  = 7'd12;
   localparam logic [6:0] Hi20Unit3  = 7'd18;
   localparam logic [6:0] Lo20Unit8  = 7'd32;
   localparam logic [6:0] Hi20Unit8  = 7'd48;
   localparam logic [6:0] Lo20Unit16 = 7'd64;
   localparam logic [6:0] Hi20Unit16 = 7'd96;
   localparam logic [6:0] Lo10Unit4  = 7'd36;
   localparam logic [6:0] Hi10Unit4  = 7'd44;

endpackage

@@ hdl/ir_pulse_distance_decoder.sv @@
// ir pulse distance decoder: edge timing classification, frame shift and key check
// result path: an accepted edge transaction is held in the input register, and its result in the result register
// throughput: one edge transaction per cycle, set by the single compute stage
//   between the input register and the result register; stalls only when a
//   finished result is held by rsp_stall and the next edge is in the input register
// reset: synchronous, clears timestamps, start flag, shift word, bit count and
//   both pipeline valids; own_address resets to 0 and pulse_unit_us to 560
`timescale 1ns / 1ps

module ir_pulse_distance_decoder (
   input  logic                           clock,
   input  logic                           reset,
   // edge input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ipd_pkg::req_type               req_payload,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ipd_pkg::rsp_type               rsp_payload,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ipd_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // registers
   logic [15:0]      own_address_ff;
   logic [11:0]      pulse_unit_ff;
   logic             in_valid_ff, in_valid_in;
   ipd_pkg::req_type in_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ipd_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]      last_fall_ff, last_fall_in;
   logic [31:0]      last_rise_ff, last_rise_in;
   logic             start_seen_ff, start_seen_in;
   logic [31:0]      shift_ff, shift_in;
   logic [5:0]       bits_ff, bits_in;

   logic accept;
   logic fire;
   logic cfg_write;

   // compute stage signals
   logic [31:0] dur;
   logic [35:0] dur5;
   logic [35:0] dur10;
   logic        is_start;
   logic        is_rep_gap;
   logic        is_zero;
   logic        is_one;
   logic        is_frame;
   logic        rep_hit;
   logic [5:0]  bits_base;
   logic [5:0]  bits_step;
   logic [31:0] shift_step;
   logic        key_hit;
   logic        produce;

   // scaled window test: lo*U <= dscaled <= hi*U
   function automatic logic in_band(input logic [35:0] dscaled, input logic [11:0] unit,
                                    input logic [6:0] lo, input logic [6:0] hi);
      logic [35:0] u;
      u = {24'b0, unit};
      return (dscaled >= u * {29'b0, lo}) && (dscaled <= u * {29'b0, hi});
   endfunction

   // bit reversal of a byte
   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   // handshakes
   assign fire      = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // register read
   always_comb begin
      case (paddr[2])
         ipd_pkg::RegOwnAddress: prdata = {16'b0, own_address_ff};
         ipd_pkg::RegPulseUnit:  prdata = {20'b0, pulse_unit_ff};
         default:                prdata = 32'b0;
      endcase
   end

   // duration and window classification
   always_comb begin
      dur        = in_ff.level ? (in_ff.time_us - last_fall_ff) : (in_ff.time_us - last_rise_ff);
      dur5       = {4'b0, dur} * 36'd5;
      dur10      = {4'b0, dur} * 36'd10;
      is_start   = in_band(dur5, pulse_unit_ff, ipd_pkg::Lo20Unit16, ipd_pkg::Hi20Unit16);
      is_rep_gap = in_band(dur10, pulse_unit_ff, ipd_pkg::Lo10Unit4, ipd_pkg::Hi10Unit4);
      is_zero    = in_band(dur5, pulse_unit_ff, ipd_pkg::Lo20Unit1, ipd_pkg::Hi20Unit1);
      is_one     = in_band(dur5, pulse_unit_ff, ipd_pkg::Lo20Unit3, ipd_pkg::Hi20Unit3);
      is_frame   = in_band(dur5, pulse_unit_ff, ipd_pkg::Lo20Unit8, ipd_pkg::Hi20Unit8);
   end

   // falling edge: repeat, bit shift, frame check
   always_comb begin
      rep_hit    = is_rep_gap && start_seen_ff;
      bits_base  = rep_hit ? 6'd0 : bits_ff;
      bits_step  = bits_base;
      shift_step = shift_ff;
      if (is_zero) begin
         shift_step = {shift_ff[30:0], 1'b0};
         bits_step  = bits_base + 6'd1;
      end else if (is_one) begin
         shift_step = {shift_ff[30:0], 1'b1};
         bits_step  = bits_base + 6'd1;
      end else if (is_frame) begin
         shift_step = 32'b0;
         bits_step  = 6'd0;
      end
      key_hit = (bits_step == ipd_pkg::FrameBits) && (shift_step[31:16] == own_address_ff)
                && ((shift_step[15:8] ^ shift_step[7:0]) == ipd_pkg::CmdCheck);
   end

   // next state of the decoder and result slot
   always_comb begin
      last_fall_in  = last_fall_ff;
      last_rise_in  = last_rise_ff;
      start_seen_in = start_seen_ff;
      shift_in      = shift_ff;
      bits_in       = bits_ff;
      produce       = 1'b0;
      rsp_in        = rsp_ff;
      if (fire) begin
         if (in_ff.level) begin
            last_rise_in  = in_ff.time_us;
            start_seen_in = is_start;
         end else begin
            last_fall_in = in_ff.time_us;
            shift_in     = shift_step;
            bits_in      = (bits_step == ipd_pkg::FrameBits) ? 6'd0 : bits_step;
            if (key_hit) begin
               produce            = 1'b1;
               rsp_in.is_repeat   = 1'b0;
               rsp_in.key_code    = reverse8(shift_step[15:8]);
            end else if (rep_hit) begin
               produce            = 1'b1;
               rsp_in.is_repeat   = 1'b1;
               rsp_in.key_code    = 8'd0;
            end
         end
      end
      rsp_valid_in = fire ? produce : (rsp_valid_ff && rsp_stall);
      in_valid_in  = accept || (in_valid_ff && !fire);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= ipd_pkg::OwnAddressReset;
         pulse_unit_ff  <= ipd_pkg::PulseUnitReset;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_fall_ff   <= 32'b0;
         last_rise_ff   <= 32'b0;
         start_seen_ff  <= 1'b0;
         shift_ff       <= 32'b0;
         bits_ff        <= 6'b0;
      end else begin
         if (cfg_write) begin
            case (paddr[2])
               ipd_pkg::RegOwnAddress: own_address_ff <= pwdata[15:0];
               ipd_pkg::RegPulseUnit:  pulse_unit_ff  <= pwdata[11:0];
               default: ;
            endcase
         end
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_fall_ff  <= last_fall_in;
         last_rise_ff  <= last_rise_in;
         start_seen_ff <= start_seen_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a repeat result always carries a zero key
   a_repeat_zero_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_repeat |-> rsp_ff.key_code == 8'd0)
      else $error("repeat result with nonzero key");

   // bit count is cleared whenever a full frame is reached
   a_bits_below_frame: assert property (@(posedge clock) disable iff (reset)
      bits_ff < ipd_pkg::FrameBits)
      else $error("bit count left at or above frame length");

   // the input side stalls only while the input register is occupied
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall with empty input register");

   // a rising edge never leaves a result behind
   a_rise_no_result: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.level |=> !rsp_valid_ff)
      else $error("rising edge produced a result");

   // an accepted transaction is held in the input register next cycle
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted transaction lost");

endmodule
